[src/virtual_timer_bank_macros.svh]
// Assertion macros shared by the timer bank RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef VIRTUAL_TIMER_BANK_MACROS_SVH
`define VIRTUAL_TIMER_BANK_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define VTB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank check failed");
// Next-cycle implication, disabled during reset.
`define VTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank check failed");
`else
`define VTB_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define VTB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/vtb_pkg.sv]
// Types and fixed field widths for the virtual timer bank.
// No dependencies; imported by virtual_timer_bank.
`timescale 1ns / 1ps

package vtb_pkg;

  localparam int unsigned OpW        = 2;
  localparam int unsigned IdW        = 4;
  localparam int unsigned PeriodW    = 32;
  localparam int unsigned CountW     = 32;
  localparam int unsigned MaskW      = 16;
  localparam int unsigned VisibleMax = 16;

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef logic [CountW-1:0] count_t;

endpackage

[src/virtual_timer_bank.sv]
// Virtual timer bank: a bank of one-shot countdown timers with tick, set and release.
// Depends on vtb_pkg and on virtual_timer_bank_macros.svh for its checks.
`timescale 1ns / 1ps
// A result passes through the stage 1, stage 2 and stage 3 registers and then the output register.
// Throughput: one item per cycle; a new transfer is taken every cycle while the
// output side keeps up, since the counters update in parallel in the last stage.
// The reciprocal multiply for the period conversion sets the first two stages.
// Reset (synchronous, active high) clears all counters to free and empties the pipeline.

`include "virtual_timer_bank_macros.svh"

module virtual_timer_bank #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TICK_MS    = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  vtb_pkg::op_t               operation,
  input  logic [vtb_pkg::IdW-1:0]    timer_id,
  input  logic [vtb_pkg::PeriodW-1:0] period_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       set_accepted,
  output logic [vtb_pkg::IdW-1:0]    free_id,
  output logic [vtb_pkg::MaskW-1:0]  fired_mask,
  output logic                       id_fired
);

  import vtb_pkg::*;

  // Timers visible on the result ports: fired_mask and free_id cover at most sixteen.
  localparam int unsigned Visible = (NUM_TIMERS < VisibleMax) ? NUM_TIMERS : VisibleMax;

  // Division by the tick length is a multiply by floor((2^32 - 1) / TICK_MS)
  // and a shift by 32. The estimate is low by at most one, and a single
  // remainder compare fixes it.
  localparam logic [PeriodW-1:0] Recip =
    PeriodW'(64'(32'hFFFF_FFFF) / 64'(TICK_MS));
  localparam int unsigned TickW = $clog2(TICK_MS + 1);
  localparam logic [TickW-1:0] TickVal = TickW'(TICK_MS);

  // Pipeline control.
  logic v1, v2, v3;
  logic adv_out, free3, free2, free1, take3;

  // Stage 1: registered input item.
  op_t                op1;
  logic [IdW-1:0]     id1;
  logic [PeriodW-1:0] per1;
  logic [2*PeriodW-1:0] prod1;

  // Stage 2: quotient estimate.
  op_t                op2;
  logic [IdW-1:0]     id2;
  logic [PeriodW-1:0] per2;
  logic [PeriodW-1:0] qe2;
  logic [PeriodW-1:0] qd2;
  logic [PeriodW-1:0] rem2;
  logic [PeriodW-1:0] quot2;
  count_t             load2;

  // Stage 3: state update and result.
  op_t             op3;
  logic [IdW-1:0]  id3;
  count_t          load3;

  count_t                  countdown [NUM_TIMERS];
  count_t                  countdown_next [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]   hit_vec;
  logic [NUM_TIMERS-1:0]   zero_vec;
  logic [NUM_TIMERS-1:0]   one_vec;
  logic [NUM_TIMERS-1:0]   zero_next;
  logic [NUM_TIMERS-1:0]   one_next;
  logic                    accepted_c;
  logic [IdW-1:0]          free_c;
  logic [MaskW-1:0]        mask_c;
  logic                    fired_c;

  // A stage can take a new item when it is empty or its item moves on this cycle.
  assign adv_out  = !out_valid || !out_stall;
  assign free3    = !v3 || adv_out;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign take3    = v3 && adv_out;
  assign in_stall = !free1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free1) v1 <= in_valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (adv_out) out_valid <= v3;
    end
  end

  // Stage 1 to 2: the wide multiply gets a register of its own.
  assign prod1 = 64'(per1) * 64'(Recip);

  always_ff @(posedge clk) begin
    if (free1) begin
      op1  <= operation;
      id1  <= timer_id;
      per1 <= period_ms;
    end
    if (free2) begin
      op2  <= op1;
      id2  <= id1;
      per2 <= per1;
      qe2  <= prod1[2*PeriodW-1:PeriodW];
    end
  end

  // Stage 2: correct the quotient and form the load value, saturating at all ones.
  always_comb begin
    qd2   = PeriodW'(qe2 * TickVal);
    rem2  = per2 - qd2;
    quot2 = (rem2 >= PeriodW'(TICK_MS)) ? qe2 + PeriodW'(1) : qe2;
    load2 = (quot2 == '1) ? '1 : CountW'(quot2) + CountW'(1);
  end

  always_ff @(posedge clk) begin
    if (free3) begin
      op3   <= op2;
      id3   <= id2;
      load3 <= load2;
    end
  end

  // Stage 3: every counter updates in parallel. Only indexes below the bank
  // size exist, so an out-of-range timer_id hits nothing.
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      hit_vec[i]  = ({3'b000, id3} == 7'(i));
      zero_vec[i] = (countdown[i] == '0);
      one_vec[i]  = (countdown[i] == CountW'(1));
      countdown_next[i] = countdown[i];
      unique case (op3)
        OP_TICK: begin
          if (countdown[i] > CountW'(1)) countdown_next[i] = countdown[i] - CountW'(1);
        end
        OP_SET: begin
          if (hit_vec[i] && zero_vec[i]) countdown_next[i] = load3;
        end
        OP_RELEASE: begin
          if (hit_vec[i]) countdown_next[i] = '0;
        end
        default: begin
          countdown_next[i] = countdown[i];
        end
      endcase
      zero_next[i] = (countdown_next[i] == '0);
      one_next[i]  = (countdown_next[i] == CountW'(1));
    end
  end

  // Results describe the state after the update. Timer zero is never offered as free.
  always_comb begin
    accepted_c = (op3 == OP_SET) && (|(hit_vec & zero_vec));
    fired_c    = |(hit_vec & one_next);
    free_c     = '0;
    mask_c     = '0;
    for (int i = Visible - 1; i >= 1; i--) begin
      if (zero_next[i]) free_c = IdW'(i);
    end
    for (int i = 0; i < Visible; i++) begin
      mask_c[i] = one_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) countdown[i] <= '0;
    end else if (take3) begin
      for (int i = 0; i < NUM_TIMERS; i++) countdown[i] <= countdown_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (take3) begin
      set_accepted <= accepted_c;
      free_id      <= free_c;
      fired_mask   <= mask_c;
      id_fired     <= fired_c;
    end
  end

  // A free output side drains the whole pipeline, so the input is never held.
  `VTB_ASSERT_IMPLIES(a_no_stall_when_drained, clk, rst, !out_stall, !in_stall)
  // A converted period always leaves the timer running or fired, never free.
  `VTB_ASSERT_IMPLIES(a_load_nonzero, clk, rst, v3, load3 != '0)
  // An accepted set leaves its timer occupied.
  `VTB_ASSERT_IMPLIES(a_set_occupies, clk, rst, take3 && accepted_c, !(|(hit_vec & zero_next)))
  // A tick never takes a timer out of the fired state.
  `VTB_ASSERT_IMPLIES(a_tick_keeps_fired, clk, rst, take3 && (op3 == OP_TICK), (one_vec & ~one_next) == '0)

endmodule
